/* sv/rpdr_pkg.sv */
// Shared types, constants and helper functions of the raw pixel depth repacker.
package rpdr_pkg;

    typedef enum logic [1:0] {
        DEPTH_8  = 2'd0,
        DEPTH_10 = 2'd1,
        DEPTH_12 = 2'd2,
        DEPTH_16 = 2'd3
    } t_depth_code;

    localparam logic [1:0] REG_IN_DEPTH  = 2'd0;
    localparam logic [1:0] REG_OUT_DEPTH = 2'd1;
    localparam logic [1:0] REG_SCALE     = 2'd2;
    localparam logic [1:0] REG_SWAP      = 2'd3;

    localparam int Q_DEPTH_DEF = 2;

    typedef logic [15:0][7:0] t_byte_grp;
    typedef logic [7:0][15:0] t_px_grp;

    typedef struct packed {
        t_px_grp     px;
        t_depth_code out_code;
        logic        swap;
    } t_grp_word;

    function automatic logic [4:0] depth_bits(input t_depth_code code);
        logic [4:0] bits;
        unique case (code)
            DEPTH_8:  bits = 5'd8;
            DEPTH_10: bits = 5'd10;
            DEPTH_12: bits = 5'd12;
            DEPTH_16: bits = 5'd16;
            default:  bits = 5'd8;
        endcase
        return bits;
    endfunction

    function automatic logic [15:0] depth_mask(input t_depth_code code);
        logic [15:0] mask;
        unique case (code)
            DEPTH_8:  mask = 16'h00FF;
            DEPTH_10: mask = 16'h03FF;
            DEPTH_12: mask = 16'h0FFF;
            DEPTH_16: mask = 16'hFFFF;
            default:  mask = 16'h00FF;
        endcase
        return mask;
    endfunction

endpackage

/* sv/rpdr_front.sv */
// Front end: collects input bytes into a group, then unpacks and scales its eight pixels.
module rpdr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [7:0]           i_in_byte,
    input  logic                 i_frame_start,
    input  rpdr_pkg::t_depth_code i_in_code,
    input  rpdr_pkg::t_depth_code i_out_code,
    input  logic                 i_scale,
    input  logic                 i_swap,
    input  logic                 i_q_ready,
    output logic                 o_full,
    output logic                 o_q_push,
    output rpdr_pkg::t_grp_word  o_q_word
);
    import rpdr_pkg::*;

    logic [4:0] r_count;
    logic [4:0] n_count;
    logic       r_done;
    logic       n_done;
    t_byte_grp  r_store;
    logic [4:0] base;
    logic [4:0] nxt;
    logic       accept;
    t_px_grp    raw_px;

    function automatic t_px_grp unpack(input t_depth_code code, input t_byte_grp b);
        t_px_grp v;
        v = '0;
        unique case (code)
            DEPTH_8: begin
                for (int i = 0; i < 8; i++) begin
                    v[i] = {8'h00, b[i]};
                end
            end
            DEPTH_10: begin
                v[0] = {6'h00, b[1], b[0][7:6]};
                v[1] = {6'h00, b[0][5:0], b[3][7:4]};
                v[2] = {6'h00, b[3][3:0], b[2][7:2]};
                v[3] = {6'h00, b[2][1:0], b[5]};
                v[4] = {6'h00, b[4], b[7][7:6]};
                v[5] = {6'h00, b[7][5:0], b[6][7:4]};
                v[6] = {6'h00, b[6][3:0], b[9][7:2]};
                v[7] = {6'h00, b[9][1:0], b[8]};
            end
            DEPTH_12: begin
                for (int i = 0; i < 2; i++) begin
                    v[4*i]   = {4'h0, b[6*i+1], b[6*i][7:4]};
                    v[4*i+1] = {4'h0, b[6*i][3:0], b[6*i+3]};
                    v[4*i+2] = {4'h0, b[6*i+2], b[6*i+5][7:4]};
                    v[4*i+3] = {4'h0, b[6*i+5][3:0], b[6*i+4]};
                end
            end
            DEPTH_16: begin
                for (int i = 0; i < 8; i++) begin
                    v[i] = {b[2*i+1], b[2*i]};
                end
            end
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] scale_px(input logic [15:0] p, input logic [4:0] ib,
                                             input logic [4:0] ob, input logic shift,
                                             input logic [15:0] mask);
        logic [23:0] wide;
        wide = {8'h00, p};
        if (shift && (ob < ib)) begin
            wide = {8'h00, p >> (ib - ob)};
        end else if (shift && (ob > ib)) begin
            wide = {8'h00, p} << (ob - ib);
        end
        return wide[15:0] & mask;
    endfunction

    assign o_full   = r_done && !i_q_ready;
    assign accept   = i_push && !o_full;
    assign base     = i_frame_start ? 5'd0 : r_count;
    assign nxt      = base + 5'd1;
    assign o_q_push = r_done && i_q_ready;
    assign raw_px   = unpack(i_in_code, r_store);

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            o_q_word.px[i] = scale_px(raw_px[i], depth_bits(i_in_code), depth_bits(i_out_code),
                                      i_scale, depth_mask(i_out_code));
        end
        o_q_word.out_code = i_out_code;
        o_q_word.swap     = i_swap;
    end

    always_comb begin
        n_count = r_count;
        n_done  = r_done;
        if (o_q_push) begin
            n_done = 1'b0;
        end
        if (accept) begin
            if (nxt >= depth_bits(i_in_code)) begin
                n_count = 5'd0;
                n_done  = 1'b1;
            end else begin
                n_count = nxt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 5'd0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_store[base[3:0]] <= i_in_byte;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < 5'd16)
        else $error("byte count out of range");

    a_no_accept_when_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !i_q_ready) |=> r_done)
        else $error("completed group lost while queue full");

endmodule

/* sv/rpdr_fifo.sv */
// Short queue of unpacked pixel groups between the front and back ends.
module rpdr_fifo #(
    parameter int DEPTH = rpdr_pkg::Q_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rpdr_pkg::t_grp_word i_word,
    output logic                o_ready,
    input  logic                i_pop,
    output logic                o_valid,
    output rpdr_pkg::t_grp_word o_word
);
    import rpdr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_grp_word       r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_word  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue count exceeds depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with empty count");

endmodule

/* sv/rpdr_back.sv */
// Back end: packs a pixel group to output depth; one byte per cycle unless pop stalls.
module rpdr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  rpdr_pkg::t_grp_word i_q_word,
    output logic                o_q_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output logic [7:0]          o_out_byte,
    output logic                o_group_last
);
    import rpdr_pkg::*;

    logic       r_busy;
    t_byte_grp  r_bytes;
    logic [4:0] r_nbytes;
    logic [3:0] r_idx;
    logic       r_ovld;
    logic [7:0] r_obyte;
    logic       r_olast;
    logic       adv;
    logic       is_last;
    logic       load;

    function automatic t_byte_grp pack(input t_depth_code code, input logic swap,
                                       input t_px_grp v);
        t_byte_grp b;
        b = '0;
        unique case (code)
            DEPTH_8: begin
                for (int i = 0; i < 8; i++) begin
                    b[i] = v[i][7:0];
                end
            end
            DEPTH_10: begin
                b[0] = {v[0][1:0], v[1][9:4]};
                b[1] = v[0][9:2];
                b[2] = {v[2][5:0], v[3][9:8]};
                b[3] = {v[1][3:0], v[2][9:6]};
                b[4] = v[4][9:2];
                b[5] = v[3][7:0];
                b[6] = {v[5][3:0], v[6][9:6]};
                b[7] = {v[4][1:0], v[5][9:4]};
                b[8] = v[7][7:0];
                b[9] = {v[6][5:0], v[7][9:8]};
            end
            DEPTH_12: begin
                for (int i = 0; i < 2; i++) begin
                    b[6*i]   = {v[4*i][3:0], v[4*i+1][11:8]};
                    b[6*i+1] = v[4*i][11:4];
                    b[6*i+2] = v[4*i+2][11:4];
                    b[6*i+3] = v[4*i+1][7:0];
                    b[6*i+4] = v[4*i+3][7:0];
                    b[6*i+5] = {v[4*i+2][3:0], v[4*i+3][11:8]};
                end
            end
            DEPTH_16: begin
                for (int i = 0; i < 8; i++) begin
                    b[2*i]   = swap ? v[i][15:8] : v[i][7:0];
                    b[2*i+1] = swap ? v[i][7:0] : v[i][15:8];
                end
            end
            default: b = '0;
        endcase
        return b;
    endfunction

    assign adv          = !r_ovld || i_pop;
    assign is_last      = ({1'b0, r_idx} == (r_nbytes - 5'd1));
    assign load         = i_q_valid && (!r_busy || (adv && is_last));
    assign o_q_pop      = load;
    assign o_empty      = !r_ovld;
    assign o_out_byte   = r_obyte;
    assign o_group_last = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ovld <= 1'b0;
            r_idx  <= 4'd0;
        end else begin
            if (adv) begin
                r_ovld <= r_busy;
            end
            if (load) begin
                r_busy <= 1'b1;
                r_idx  <= 4'd0;
            end else if (adv && r_busy) begin
                if (is_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_busy) begin
            r_obyte <= r_bytes[r_idx];
            r_olast <= is_last;
        end
        if (load) begin
            r_bytes  <= pack(i_q_word.out_code, i_q_word.swap, i_q_word.px);
            r_nbytes <= depth_bits(i_q_word.out_code);
        end
    end

    a_idx_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ({1'b0, r_idx} < r_nbytes))
        else $error("byte index beyond output group");

    a_last_ends_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_busy && is_last && !load) |=> !r_busy)
        else $error("group did not end after its last word");

endmodule

/* sv/raw_pixel_depth_repacker.sv */
// Top level of the raw pixel depth repacker: configuration registers and the three stages.
//
//  Channel   Direction  Handshake              Payload
//  input     in         push / full            i_in_byte, i_frame_start
//  result    out        empty / pop            o_out_byte, o_group_last
//  config    in         i_cfg_we (no wait)     i_cfg_idx, i_cfg_data
//
// One input word is taken per cycle while full is low; the back end sends one output word
// per cycle while pop is high or its output register is empty.
// A group moves to the output via the done flag, queue, byte store and output register.
// Reset clears the configuration to its defaults, the byte count, the queue and the output.
// full rises only when a completed group waits while the queue is full.
module raw_pixel_depth_repacker #(
    parameter int Q_DEPTH = rpdr_pkg::Q_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_frame_start,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_group_last,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [1:0] i_cfg_data
);
    import rpdr_pkg::*;

    t_depth_code r_in_code;
    t_depth_code r_out_code;
    logic        r_scale;
    logic        r_swap;
    logic        q_ready;
    logic        q_push;
    t_grp_word   q_in;
    logic        q_valid;
    logic        q_pop;
    t_grp_word   q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_code  <= DEPTH_10;
            r_out_code <= DEPTH_8;
            r_scale    <= 1'b1;
            r_swap     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IN_DEPTH:  r_in_code  <= t_depth_code'(i_cfg_data);
                REG_OUT_DEPTH: r_out_code <= t_depth_code'(i_cfg_data);
                REG_SCALE:     r_scale    <= i_cfg_data[0];
                REG_SWAP:      r_swap     <= i_cfg_data[0];
                default:       r_swap     <= r_swap;
            endcase
        end
    end

    rpdr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_in_byte    (i_in_byte),
        .i_frame_start(i_frame_start),
        .i_in_code    (r_in_code),
        .i_out_code   (r_out_code),
        .i_scale      (r_scale),
        .i_swap       (r_swap),
        .i_q_ready    (q_ready),
        .o_full       (full),
        .o_q_push     (q_push),
        .o_q_word     (q_in)
    );

    rpdr_fifo #(
        .DEPTH(Q_DEPTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_word (q_in),
        .o_ready(q_ready),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_word (q_out)
    );

    rpdr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_word    (q_out),
        .o_q_pop     (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_byte  (o_out_byte),
        .o_group_last(o_group_last)
    );

endmodule
